>>> hw/rtl/bsfo_pkg.sv
// Shared types, widths and codes for the binary search first-occurrence block.
package bsfo_pkg;

   localparam int STORE_DEPTH_DEFAULT   = 1024;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;

   localparam int INDEX_WIDTH    = 10;
   localparam int VALUE_WIDTH    = 32;
   localparam int COUNT_WIDTH    = 11;
   localparam int POSITION_WIDTH = 10;

   // Reciprocal scaling for the write index reduction modulo the store depth
   localparam int RECIP_SHIFT = 2 * INDEX_WIDTH;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   typedef struct packed {
      logic                          action;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [POSITION_WIDTH-1:0] position;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic wr_quot;
      logic wr_rem;
      logic wr_store;
      logic probe;
      logic step_right;
      logic step_left;
      logic read_prev;
      logic set_hit;
      logic set_miss;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic active;
      logic key_gt;
      logic key_lt;
      logic mid_zero;
      logic prev_differs;
   } sts_type;

endpackage

>>> hw/rtl/bsfo_dpath.sv
// Datapath: element store, search bounds, write index reduction and result registers.
module bsfo_dpath #(
   parameter int STORE_DEPTH   = bsfo_pkg::STORE_DEPTH_DEFAULT,
   parameter int ELEMENT_WIDTH = bsfo_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bsfo_pkg::req_type                   req_data,
   input  logic                                csr_wr_en,
   input  logic [bsfo_pkg::COUNT_WIDTH-1:0]    csr_wr_data,
   input  bsfo_pkg::cmd_type                   cmd,
   output bsfo_pkg::sts_type                   sts,
   output bsfo_pkg::rsp_type                   rsp_data
);
   import bsfo_pkg::*;

   localparam int AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LW      = AW + 2;
   localparam int DEPTH_W = $clog2(STORE_DEPTH + 1);
   localparam int SW      = ((COUNT_WIDTH > AW + 1) ? COUNT_WIDTH : AW + 1) + 1;
   localparam int PW      = INDEX_WIDTH + RECIP_SHIFT + 1;
   localparam int MW      = INDEX_WIDTH + DEPTH_W;
   localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'((2 ** RECIP_SHIFT) / STORE_DEPTH);

   logic [ELEMENT_WIDTH-1:0] mem [STORE_DEPTH];

   logic [COUNT_WIDTH-1:0]          count_ff;
   logic signed [ELEMENT_WIDTH-1:0] key_ff;
   logic [INDEX_WIDTH-1:0]          idx_ff;
   logic signed [LW-1:0]            low_ff, low_in;
   logic signed [LW-1:0]            high_ff, high_in;
   logic [AW-1:0]                   mid_ff;
   logic signed [ELEMENT_WIDTH-1:0] rd_ff;
   logic [INDEX_WIDTH-1:0]          quot_ff;
   logic [AW:0]                     rem_ff;
   logic                            res_found_ff;
   logic [POSITION_WIDTH-1:0]       res_pos_ff;
   rsp_type                         rsp_ff;

   logic [VALUE_WIDTH+64-1:0]       value_wide;
   logic [SW-1:0]                   count_wide, depth_wide, n_sel;
   logic [LW:0]                     mid_sum;
   logic [AW-1:0]                   mid_c;
   logic [LW-1:0]                   mid_ext;
   logic [AW-1:0]                   rd_addr;
   logic [PW-1:0]                   quot_prod;
   logic [MW-1:0]                   rem_full;
   logic [AW:0]                     rem_adj;
   logic [POSITION_WIDTH+AW-1:0]    pos_wide;

   // Sign-extend the 32-bit value, then keep ELEMENT_WIDTH bits
   assign value_wide = {{64{req_data.value[VALUE_WIDTH-1]}}, req_data.value};

   assign count_wide = SW'(count_ff);
   assign depth_wide = SW'(STORE_DEPTH);
   assign n_sel      = (count_wide > depth_wide) ? depth_wide : count_wide;

   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_c   = mid_sum[AW:1];
   assign mid_ext = {2'b00, mid_ff};
   assign rd_addr = cmd.read_prev ? (mid_ff - AW'(1)) : mid_c;

   assign quot_prod = PW'(idx_ff) * PW'(RECIP);
   assign rem_full  = MW'(idx_ff) - (MW'(quot_ff) * MW'(STORE_DEPTH));
   assign rem_adj   = (rem_ff >= (AW + 1)'(STORE_DEPTH)) ? (rem_ff - (AW + 1)'(STORE_DEPTH))
                                                         : rem_ff;
   assign pos_wide  = {{POSITION_WIDTH{1'b0}}, mid_ff};

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.capture) begin
         low_in  = '0;
         high_in = $signed(n_sel[LW-1:0]) - $signed(LW'(1));
      end else if (cmd.step_right) begin
         low_in  = mid_ext + LW'(1);
      end else if (cmd.step_left) begin
         high_in = mid_ext - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      if (cmd.capture) begin
         key_ff <= value_wide[ELEMENT_WIDTH-1:0];
         idx_ff <= req_data.index;
      end
      if (cmd.probe) begin
         mid_ff <= mid_c;
      end
      if (cmd.wr_quot) begin
         quot_ff <= quot_prod[RECIP_SHIFT +: INDEX_WIDTH];
      end
      if (cmd.wr_rem) begin
         rem_ff <= rem_full[AW:0];
      end
      if (cmd.set_hit) begin
         res_found_ff <= 1'b1;
         res_pos_ff   <= pos_wide[POSITION_WIDTH-1:0];
      end else if (cmd.set_miss) begin
         res_found_ff <= 1'b0;
         res_pos_ff   <= '0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.found    <= res_found_ff;
         rsp_ff.position <= res_pos_ff;
      end
   end

   // Element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_store) begin
         mem[rem_adj[AW-1:0]] <= key_ff;
      end
      if (cmd.probe || cmd.read_prev) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign sts.active       = (high_ff >= low_ff);
   assign sts.key_gt       = (key_ff > rd_ff);
   assign sts.key_lt       = (key_ff < rd_ff);
   assign sts.mid_zero     = (mid_ff == '0);
   assign sts.prev_differs = (rd_ff != key_ff);

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/bsfo_ctrl.sv
// Controller: sequences write reduction, search probes and result hand-off.
module bsfo_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsfo_pkg::cmd_type cmd,
   input  bsfo_pkg::sts_type sts
);
   import bsfo_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WR_Q   = 3'd1;
   localparam logic [2:0] S_WR_R   = 3'd2;
   localparam logic [2:0] S_WR_ST  = 3'd3;
   localparam logic [2:0] S_PROBE  = 3'd4;
   localparam logic [2:0] S_CMP    = 3'd5;
   localparam logic [2:0] S_PREV   = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_action == ACTION_SEARCH) ? S_PROBE : S_WR_Q;
            end
         end
         S_WR_Q: begin
            cmd.wr_quot = 1'b1;
            state_in    = S_WR_R;
         end
         S_WR_R: begin
            cmd.wr_rem = 1'b1;
            state_in   = S_WR_ST;
         end
         S_WR_ST: begin
            cmd.wr_store = 1'b1;
            state_in     = S_IDLE;
         end
         S_PROBE: begin
            if (sts.active) begin
               cmd.probe = 1'b1;
               state_in  = S_CMP;
            end else begin
               cmd.set_miss = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_CMP: begin
            if (sts.key_gt) begin
               cmd.step_right = 1'b1;
               state_in       = S_PROBE;
            end else if (sts.key_lt) begin
               cmd.step_left = 1'b1;
               state_in      = S_PROBE;
            end else if (sts.mid_zero) begin
               cmd.set_hit = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.read_prev = 1'b1;
               state_in      = S_PREV;
            end
         end
         S_PREV: begin
            if (sts.prev_differs) begin
               cmd.set_hit = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.step_left = 1'b1;
               state_in      = S_PROBE;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/binary_search_first_occurrence.sv
// Top level of the binary search first-occurrence block.
// A word on the req_ channel either writes value into the element store at
// index (action 0; the index wraps modulo STORE_DEPTH) or searches for value
// as a key (action 1) over the first element_count entries, which csr_wr_data
// sets and which saturates at STORE_DEPTH. A search returns one rsp_ word with
// found and the lowest matching position; a miss or an empty array gives
// found 0 and position 0. A write returns nothing. The store has no reset:
// load every entry inside element_count before searching, and keep the data
// sorted ascending as signed numbers. A write occupies the block through the
// accept and a three-step index reduction. A search spends a probe state and
// a compare state on each probe, set by the single store read port with its
// registered read data, plus a neighbor-read state on each hit whose left
// neighbor must be checked, plus a final probe state on a miss to find the
// range empty, with an accept state before and a hand-off state after. Over n
// searched entries a search makes at most floor(log2(n))+1 probes, and runs
// of duplicates take more. The result sits in an output register, so a new
// word is taken while the previous result waits for the consumer; a search
// that finishes before that result is taken holds until it is.
module binary_search_first_occurrence #(
   parameter int STORE_DEPTH   = bsfo_pkg::STORE_DEPTH_DEFAULT,
   parameter int ELEMENT_WIDTH = bsfo_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bsfo_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bsfo_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [bsfo_pkg::COUNT_WIDTH-1:0] csr_wr_data
);
   import bsfo_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence the work: accept, reduce and store, or probe and report
   bsfo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Hold the store, the bounds, the count register and the output word
   bsfo_dpath #(
      .STORE_DEPTH   (STORE_DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule
